@@ rtl/bbcw_pkg.sv @@
// Shared types and constants of the clipped-window box blur.
package bbcw_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 3;
    localparam int MAX_HEIGHT     = 4096;
    localparam int PIX_W          = 8;

    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_WIN_W    = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [CFG_WIN_W-1:0]    RST_WINDOW_SIZE  = 3'd3;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] in_blue;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_red;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
        logic             frame_end;
    } out_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic pixel_write;
        logic win_start;
        logic win_step;
        logic div_start;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic input_complete;
        logic emit_due;
        logic win_last;
        logic div_done;
    } ctl_stat_t;

endpackage

@@ rtl/bbcw_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bbcw_div import bbcw_pkg::*; #(
    parameter int SUM_W = 14,
    parameter int CNT_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [PIX_W-1:0] quotient
);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W:0]    trial;

    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign done     = (step_reg == '0);
    assign quotient = quo_reg[PIX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (start) begin
            step_reg <= STEP_W'(SUM_W);
        end else if (!done) begin
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (!done) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_reg <= CNT_W'(trial - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

@@ rtl/bbcw_ctrl.sv @@
// Sequencer of the box blur: item handshakes, window sweep, divide, output.
module bbcw_ctrl import bbcw_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_cmd,
    output logic      m_valid,
    input  logic      m_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_WIN, ST_WAIT, ST_DSTART, ST_DIV, ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign accept   = s_valid && s_ready;
    // output register can take a new item this cycle
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_DRAIN) begin
                        if (stat.input_complete) begin
                            cmd.win_start = 1'b1;
                            state_next    = ST_WIN;
                        end
                    end else if (!stat.input_complete) begin
                        cmd.pixel_write = 1'b1;
                        if (stat.emit_due) begin
                            cmd.win_start = 1'b1;
                            state_next    = ST_WIN;
                        end
                    end
                end
            end
            ST_WIN: begin
                cmd.win_step = 1'b1;
                if (stat.win_last) state_next = ST_WAIT;
            end
            ST_WAIT:   state_next = ST_DSTART;
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/bbcw_dp.sv @@
// Datapath: config, positions, pixel history memory, window sums, dividers.
module bbcw_dp import bbcw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              s_data,
    input  ctl_cmd_t              cmd,
    output ctl_stat_t             stat,
    output out_item_t             m_data
);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int LW    = RW + CW;
    localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int RDW   = $clog2(MAX_RADIUS + 1);
    localparam int KW    = $clog2(2 * MAX_RADIUS + 1);
    localparam int CNT_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUM_W = PIX_W + CNT_W;
    localparam int RRW   = RW + KW + 1;
    localparam int CCW   = CW + KW + 1;

    // config
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CFG_WIN_W-1:0]    win_reg;
    logic                    cfg_hit;

    logic [WW-1:0]        uw;
    logic [HW-1:0]        uh;
    logic [CFG_WIN_W-1:0] rs;
    logic [RDW-1:0]       ur;
    logic [LW-1:0]        lag;
    logic [KW-1:0]        span;

    // positions
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [RW-1:0] in_row_reg, out_row_reg;
    logic [LW-1:0] in_lin_reg, out_lin_reg;
    logic [AW-1:0] in_ptr_reg, out_ptr_reg;
    logic          done_in_reg;
    logic          last_out;

    // window sweep
    logic [KW-1:0]  dy_reg, dx_reg;
    logic [AW-1:0]  row_base_reg, rd_addr_reg;
    logic [AW:0]    base_diff, row_add;
    logic [AW-1:0]  base_start, row_next;
    logic [RRW-1:0] rr;
    logic [CCW-1:0] cc;
    logic           in_win;
    logic           rd_en_reg;

    pixel_t mem [DEPTH];
    pixel_t rd_data_reg;

    logic [SUM_W-1:0] sum_b_reg, sum_g_reg, sum_r_reg;
    logic [CNT_W-1:0] cnt_reg, divisor;
    logic [2:0]       div_done;
    logic [PIX_W-1:0] q_b, q_g, q_r;
    out_item_t        out_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        if (width_reg == '0) uw = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH) uw = WW'(MAX_WIDTH);
        else uw = WW'(width_reg);

        if (height_reg == '0) uh = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT) uh = HW'(MAX_HEIGHT);
        else uh = HW'(height_reg);

        rs = (win_reg == '0) ? '0 : ((win_reg - 1'b1) >> 1);
        ur = (32'(rs) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(rs);
    end

    assign lag  = LW'(LW'(ur) * LW'(uw)) + LW'(ur);
    assign span = KW'({ur, 1'b0});

    assign last_out = (RW'(out_row_reg) == RW'(uh - 1'b1))
                   && (CW'(out_col_reg) == CW'(uw - 1'b1));

    assign stat.input_complete = done_in_reg;
    assign stat.emit_due = {1'b0, in_lin_reg} >= ({1'b0, out_lin_reg} + {1'b0, lag});
    assign stat.win_last = (dx_reg == span) && (dy_reg == span);
    assign stat.div_done = &div_done;

    always_comb begin
        unique case (cfg_addr) inside
            CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_WINDOW_SIZE: cfg_hit = cfg_wr_en;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            win_reg    <= RST_WINDOW_SIZE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[CFG_WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata[CFG_HEIGHT_W-1:0];
                CFG_WINDOW_SIZE:  win_reg    <= cfg_wdata[CFG_WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // frame positions; a register write or the last output restarts the frame
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit || (cmd.out_load && last_out)) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_lin_reg  <= '0;
            in_ptr_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_lin_reg <= '0;
            out_ptr_reg <= '0;
            done_in_reg <= 1'b0;
        end else begin
            if (cmd.pixel_write) begin
                in_ptr_reg <= ptr_inc(in_ptr_reg);
                in_lin_reg <= in_lin_reg + 1'b1;
                if (WW'(in_col_reg) + 1'b1 >= uw) begin
                    in_col_reg <= '0;
                    if (HW'(in_row_reg) + 1'b1 >= uh) begin
                        in_row_reg  <= '0;
                        in_lin_reg  <= '0;
                        done_in_reg <= 1'b1;
                    end else begin
                        in_row_reg <= in_row_reg + 1'b1;
                    end
                end else begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                out_ptr_reg <= ptr_inc(out_ptr_reg);
                out_lin_reg <= out_lin_reg + 1'b1;
                if (WW'(out_col_reg) + 1'b1 >= uw) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // window addressing, circular over the history memory
    always_comb begin
        base_diff = {1'b0, out_ptr_reg} - (AW + 1)'(lag);
        if (base_diff[AW]) base_start = AW'(base_diff + (AW + 1)'(DEPTH));
        else base_start = base_diff[AW-1:0];

        row_add = {1'b0, row_base_reg} + (AW + 1)'(uw);
        if (row_add >= (AW + 1)'(DEPTH)) row_next = AW'(row_add - (AW + 1)'(DEPTH));
        else row_next = row_add[AW-1:0];

        rr = RRW'(out_row_reg) + RRW'(dy_reg) - RRW'(ur);
        cc = CCW'(out_col_reg) + CCW'(dx_reg) - CCW'(ur);
        in_win = !rr[RRW-1] && (rr < RRW'(uh)) && !cc[CCW-1] && (cc < CCW'(uw));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_en_reg <= 1'b0;
        end else begin
            rd_en_reg <= cmd.win_step && in_win;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.win_start) begin
            dy_reg       <= '0;
            dx_reg       <= '0;
            row_base_reg <= base_start;
            rd_addr_reg  <= base_start;
        end else if (cmd.win_step) begin
            if (dx_reg == span) begin
                dx_reg       <= '0;
                dy_reg       <= dy_reg + 1'b1;
                row_base_reg <= row_next;
                rd_addr_reg  <= row_next;
            end else begin
                dx_reg      <= dx_reg + 1'b1;
                rd_addr_reg <= ptr_inc(rd_addr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pixel_write) begin
            mem[in_ptr_reg] <= '{red: s_data.in_red, green: s_data.in_green,
                                 blue: s_data.in_blue};
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.win_start) begin
            sum_b_reg <= '0;
            sum_g_reg <= '0;
            sum_r_reg <= '0;
            cnt_reg   <= '0;
        end else if (rd_en_reg) begin
            sum_b_reg <= sum_b_reg + SUM_W'(rd_data_reg.blue);
            sum_g_reg <= sum_g_reg + SUM_W'(rd_data_reg.green);
            sum_r_reg <= sum_r_reg + SUM_W'(rd_data_reg.red);
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    assign divisor = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;

    bbcw_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_b (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start), .dividend(sum_b_reg),
        .divisor(divisor), .done(div_done[0]), .quotient(q_b)
    );
    bbcw_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_g (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start), .dividend(sum_g_reg),
        .divisor(divisor), .done(div_done[1]), .quotient(q_g)
    );
    bbcw_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_r (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start), .dividend(sum_r_reg),
        .divisor(divisor), .done(div_done[2]), .quotient(q_r)
    );

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= '{out_blue: q_b, out_green: q_g, out_red: q_r,
                         frame_end: last_out};
        end
    end

    assign m_data = out_reg;

endmodule

@@ rtl/box_blur_clipped_window.sv @@
// Top level of the clipped-window box blur (mean filter) over BGR pixels.
//
//   channel   ports                                 role
//   config    cfg_wr_en, cfg_addr, cfg_wdata        register writes, no wait
//   input     s_valid, s_ready, s_data (in_item_t)  pixel or drain items
//   result    m_valid, m_ready, m_data (out_item_t) blurred pixels
//
// An item that yields no result leaves s_ready high, so the next item can
// follow. An item that yields a result goes through the accept, the
// (2r+1)^2 window reads from the history memory, read drain and divide
// setup, the bit-serial dividers (SUM_W is 14 at the default MAX_RADIUS
// of 3) and finally the load into the output register.
// Synchronous active-low reset; the history memory is not cleared.
// s_ready is low while a result is computed; the load waits while the
// previous result still sits unaccepted in the output register.
module box_blur_clipped_window import bbcw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);
    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // sequencer: handshakes, step order, output valid flag
    bbcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_data.cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: line history, window sums, dividers, output register
    bbcw_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

@@ tb/sv/box_blur_checker.sv @@
// Checker for the box blur: watches the config, input and result channels, predicts results, compares.
`timescale 1ns / 1ps
module box_blur_checker import bbcw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    output int                    fail_count,
    output int                    pending_count
);
    localparam int HIST_DEPTH = 2 * DEF_MAX_RADIUS * DEF_MAX_WIDTH + 2 * DEF_MAX_RADIUS + 1;

    pixel_t    history [HIST_DEPTH];
    int        width_reg, height_reg, win_reg;
    int        in_col, in_rw, out_col, out_rw;
    bit        all_in;
    out_item_t blur_queue[$];

    function automatic int eff_width();
        return width_reg < 1 ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
    endfunction

    function automatic int eff_height();
        return height_reg < 1 ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    endfunction

    function automatic int eff_radius();
        int r;
        r = win_reg >= 1 ? (win_reg - 1) / 2 : 0;
        return r > DEF_MAX_RADIUS ? DEF_MAX_RADIUS : r;
    endfunction

    task automatic restart();
        in_col = 0; in_rw = 0; out_col = 0; out_rw = 0; all_in = 0;
    endtask

    task automatic predict_mean();
        int w, h, r, sb, sg, sr, n, rr, cc;
        pixel_t px;
        out_item_t o;
        w = eff_width(); h = eff_height(); r = eff_radius();
        sb = 0; sg = 0; sr = 0; n = 0;
        for (int dy = -r; dy <= r; dy++) begin
            rr = out_rw + dy;
            if (rr < 0 || rr >= h) continue;
            for (int dx = -r; dx <= r; dx++) begin
                cc = out_col + dx;
                if (cc < 0 || cc >= w) continue;
                px = history[(rr * w + cc) % HIST_DEPTH];
                sb += px.blue; sg += px.green; sr += px.red;
                n++;
            end
        end
        if (n == 0) n = 1;
        o.out_blue  = 8'(sb / n);
        o.out_green = 8'(sg / n);
        o.out_red   = 8'(sr / n);
        o.frame_end = (out_rw == h - 1) && (out_col == w - 1);
        blur_queue = {blur_queue, o};
        if (o.frame_end) restart();
        else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_rw++;
            end
        end
    endtask

    task automatic take_item(in_item_t it);
        int w, h, r, ipos;
        if (it.cmd == CMD_DRAIN) begin
            if (all_in) predict_mean();
            return;
        end
        if (all_in) return;
        w = eff_width(); h = eff_height(); r = eff_radius();
        ipos = in_rw * w + in_col;
        history[ipos % HIST_DEPTH] = '{red: it.in_red, green: it.in_green, blue: it.in_blue};
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_rw++;
            if (in_rw >= h) begin
                in_rw = 0;
                all_in = 1;
            end
        end
        if (ipos >= out_rw * w + out_col + r * w + r) predict_mean();
    endtask

    assign pending_count = blur_queue.size();

    always @(posedge aclk) begin
        out_item_t exp_o;
        if (!aresetn) begin
            width_reg  = int'(RST_IMAGE_WIDTH);
            height_reg = int'(RST_IMAGE_HEIGHT);
            win_reg    = int'(RST_WINDOW_SIZE);
            restart();
            blur_queue.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_IMAGE_WIDTH: begin
                        width_reg = int'(cfg_wdata[CFG_WIDTH_W-1:0]);
                        restart();
                    end
                    CFG_IMAGE_HEIGHT: begin
                        height_reg = int'(cfg_wdata[CFG_HEIGHT_W-1:0]);
                        restart();
                    end
                    CFG_WINDOW_SIZE: begin
                        win_reg = int'(cfg_wdata[CFG_WIN_W-1:0]);
                        restart();
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (blur_queue.size() == 0) begin
                    $error("unexpected result %p", m_data);
                    fail_count++;
                end else begin
                    exp_o = blur_queue.pop_front();
                    if (m_data.out_blue !== exp_o.out_blue) begin
                        $error("out_blue exp %0d got %0d", exp_o.out_blue, m_data.out_blue);
                        fail_count++;
                    end
                    if (m_data.out_green !== exp_o.out_green) begin
                        $error("out_green exp %0d got %0d", exp_o.out_green, m_data.out_green);
                        fail_count++;
                    end
                    if (m_data.out_red !== exp_o.out_red) begin
                        $error("out_red exp %0d got %0d", exp_o.out_red, m_data.out_red);
                        fail_count++;
                    end
                    if (m_data.frame_end !== exp_o.frame_end) begin
                        $error("frame_end exp %0d got %0d", exp_o.frame_end, m_data.frame_end);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) take_item(s_data);
        end
    end
endmodule

@@ tb/sv/box_blur_clipped_window_test.sv @@
// Testbench top: frames of random pixels through the box blur, checked by a monitor.
`timescale 1ns / 1ps
module box_blur_clipped_window_test;
    import bbcw_pkg::*;

    // Clock, reset and all block inputs start known.
    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  cfg_wr_en = 0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 0;
    out_item_t             m_data;
    int                    fail_count, pending_count;
    int                    cycle_count = 0;
    int                    items_sent = 0;
    // Receiver hold-off: while set, m_ready is forced low for a long run.
    bit                    hold_result = 0;
    bit                    stall_on = 1;

    // Generous cap on the run, allowing for slow result items plus receiver stalls.
    localparam int CYCLE_CAP = 1_500_000;
    localparam int DRAIN_WAIT = 200;

    initial forever #2 aclk = ~aclk;

    box_blur_clipped_window uut (.*);

    box_blur_checker chk (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls in phases, sometimes no stalls, plus the long hold.
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
        if (hold_result) m_ready <= 0;
        else if (!stall_on) m_ready <= 1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, int val);
        cfg_wr_en <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    // Wait for every expected result, then let the block settle before a write.
    task automatic settle();
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_frame(int w, int h, int ws);
        settle();
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
        cfg_write(CFG_WINDOW_SIZE, ws);
    endtask

    // Send one item; burst gaps come from a random idle before some items.
    task automatic send(logic cmd, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        if ($urandom_range(0, 7) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1;
        s_data  <= '{cmd: cmd, in_blue: b, in_green: g, in_red: r};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_pixel_rand();
        send(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // A full frame: all pixels, then enough drains for the pending outputs.
    task automatic run_frame(int w, int h, int ws, bit extremes);
        int r, drains;
        r = (ws >= 1) ? (ws - 1) / 2 : 0;
        if (r > DEF_MAX_RADIUS) r = DEF_MAX_RADIUS;
        drains = (r * w + r < w * h) ? r * w + r : w * h;
        for (int i = 0; i < w * h; i++) begin
            if (extremes) send(CMD_PIXEL, (i % 2) ? 8'hFF : 8'h00, 8'hFF, 8'h00);
            else send_pixel_rand();
            if ($urandom_range(0, 40) == 0) send(CMD_DRAIN, 8'($urandom), 0, 0);
        end
        // an extra pixel while outputs are pending is ignored
        if (drains > 0 && $urandom_range(0, 1)) send_pixel_rand();
        for (int i = 0; i < drains; i++) send(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        s_valid <= 0;
    endtask

    int fw, fh, fs;

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: drain before any pixel is ignored; tiny frames and extremes.
        send(CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        s_valid <= 0;
        set_frame(1, 1, 7);
        run_frame(1, 1, 7, 1);
        set_frame(4, 3, 7);
        run_frame(4, 3, 7, 1);
        set_frame(5, 2, 0);
        run_frame(5, 2, 0, 1);
        // out-of-range width and height are clamped to 1
        set_frame(0, 0, 2);
        run_frame(1, 1, 2, 0);
        // register write abandons a frame in flight
        set_frame(3, 3, 3);
        for (int i = 0; i < 4; i++) send_pixel_rand();
        s_valid <= 0;

        // Long receiver hold while the sender keeps offering pixels.
        set_frame(8, 6, 3);
        fork
            begin
                hold_result <= 1;
                repeat (300) @(posedge aclk);
                hold_result <= 0;
            end
            run_frame(8, 6, 3, 0);
        join

        // Random frames, small sizes mostly.
        while (items_sent < 1400) begin
            fw = $urandom_range(1, 12);
            fh = $urandom_range(1, 8);
            fs = $urandom_range(0, 7);
            set_frame(fw, fh, fs);
            run_frame(fw, fh, fs, 0);
        end
        // full width sets the top width bit; abandoned after a few pixels
        set_frame(1024, 2, 7);
        for (int i = 0; i < 40; i++) send_pixel_rand();
        s_valid <= 0;
        // big height exercises the high height bits; abandoned after few rows
        set_frame(2, 4096, 5);
        for (int i = 0; i < 12; i++) send_pixel_rand();
        s_valid <= 0;
        set_frame(2047, 8191, 1);
        for (int i = 0; i < 6; i++) send_pixel_rand();
        s_valid <= 0;

        settle();
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule

@@ files.f @@
rtl/bbcw_pkg.sv
rtl/bbcw_div.sv
rtl/bbcw_ctrl.sv
rtl/bbcw_dp.sv
rtl/box_blur_clipped_window.sv
tb/sv/box_blur_checker.sv
tb/sv/box_blur_clipped_window_test.sv
